### src/qte_pkg.sv
// shared types and constants for the quaternion to euler yaw rate unit
`timescale 1ns / 1ps
package qte_pkg;
    localparam int TableLen = 24;
    localparam logic signed [23:0] PiQ20     = 24'sd3294199;
    localparam logic signed [23:0] HalfPiQ20 = 24'sd1647099;
    localparam int AngMax   = 12868;
    localparam int PitchMax = 6434;

    typedef logic signed [15:0] t_quat;

    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd823550;
            5'd1:  v = 22'd486170;
            5'd2:  v = 22'd256879;
            5'd3:  v = 22'd130396;
            5'd4:  v = 22'd65451;
            5'd5:  v = 22'd32757;
            5'd6:  v = 22'd16383;
            5'd7:  v = 22'd8192;
            5'd8:  v = 22'd4096;
            5'd9:  v = 22'd2048;
            5'd10: v = 22'd1024;
            5'd11: v = 22'd512;
            5'd12: v = 22'd256;
            5'd13: v = 22'd128;
            5'd14: v = 22'd64;
            5'd15: v = 22'd32;
            5'd16: v = 22'd16;
            5'd17: v = 22'd8;
            5'd18: v = 22'd4;
            5'd19: v = 22'd2;
            5'd20: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction
endpackage

### src/qte_if.sv
// valid/ready channel interfaces for quaternion input and euler output
`timescale 1ns / 1ps
interface qte_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] roll_angle;
    logic signed [13:0] pitch_angle;
    logic signed [14:0] yaw_angle;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] yaw_accel;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, yaw_rate, yaw_accel,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, yaw_rate, yaw_accel,
                    output ready);
endinterface

### src/qte_mul.sv
// shift-add signed multiplier, two multiplier bits per cycle
`timescale 1ns / 1ps
module qte_mul
    import qte_pkg::*;
#(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [AW-1:0]  i_a,
    input  logic signed [BW-1:0]  i_b,
    output logic                  o_done,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int BWE = BW + (BW % 2);
    localparam int NSTEP = BWE / 2;
    localparam int CW = $clog2(NSTEP + 1);
    localparam int PW = AW + BW;

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [BWE-1:0]   r_b;
    logic signed [PW-1:0] r_acc;
    logic signed [PW-1:0] r_a;
    logic signed [PW-1:0] n_acc;
    logic signed [PW-1:0] pp0;
    logic signed [PW-1:0] pp1;
    logic             last;

    assign last = (r_cnt == CW'(NSTEP - 1));

    always_comb begin
        // top digit of a signed multiplier carries negative weight
        pp0 = r_b[0] ? r_a : '0;
        pp1 = r_b[1] ? (r_a <<< 1) : '0;
        if (last) begin
            n_acc = r_acc + pp0 - pp1;
        end else begin
            n_acc = r_acc + pp0 + pp1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_a    <= PW'(i_a);
                r_b    <= BWE'(i_b);
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_a   <= r_a <<< 2;
                r_b   <= r_b >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_p = r_acc;
endmodule

### src/qte_isqrt.sv
// bit-serial floor square root, one result bit per cycle
`timescale 1ns / 1ps
module qte_isqrt
    import qte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [49:0] i_n,
    output logic        o_done,
    output logic [24:0] o_r
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [49:0] r_n;
    logic [24:0] r_rem;
    logic [24:0] r_root;
    logic [26:0] trial;
    logic [26:0] shifted;

    assign shifted = {r_rem, r_n[49:48]};
    assign trial   = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= i_n;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_n <= r_n << 2;
                if (shifted >= trial) begin
                    r_rem  <= 25'(shifted - trial);
                    r_root <= {r_root[23:0], 1'b1};
                end else begin
                    r_rem  <= shifted[24:0];
                    r_root <= {r_root[23:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd24) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_r = r_root;
endmodule

### src/qte_cordic.sv
// vectoring cordic atan2, one iteration per cycle
`timescale 1ns / 1ps
module qte_cordic
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [39:0] i_y,
    input  logic signed [39:0] i_x,
    output logic               o_done,
    output logic signed [23:0] o_z
);
    localparam int NIT = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

    logic               r_busy;
    logic [4:0]         r_i;
    logic signed [42:0] r_x;
    logic signed [42:0] r_y;
    logic signed [23:0] r_z;
    logic signed [42:0] xs;
    logic signed [42:0] ys;
    logic signed [23:0] tab;

    assign xs  = r_x >>> r_i;
    assign ys  = r_y >>> r_i;
    assign tab = 24'(atan_entry(r_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_i    <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (i_y == 40'sd0) begin
                    r_z    <= (i_x < 0) ? PiQ20 : 24'sd0;
                    o_done <= 1'b1;
                end else begin
                    r_busy <= (NIT > 0);
                    o_done <= (NIT == 0);
                    if (i_x < 0) begin
                        r_z <= (i_y >= 0) ? PiQ20 : -PiQ20;
                        r_x <= -43'(i_x);
                        r_y <= -43'(i_y);
                    end else begin
                        r_z <= '0;
                        r_x <= 43'(i_x);
                        r_y <= 43'(i_y);
                    end
                end
            end else if (r_busy) begin
                if (r_y >= 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + tab;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - tab;
                end
                r_i <= r_i + 1'b1;
                if (r_i == 5'(NIT - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_z = r_z;
endmodule

### src/quaternion_to_euler_yaw_rate_unit.sv
// top level: quaternion to roll, pitch, yaw with yaw rate and acceleration
// usage:
//   in channel carries one quaternion (w, x, y, z, Q1.14) per transaction
//   out channel returns roll, pitch, yaw (Q2.12 rad; pitch Q1.12), yaw rate and yaw
//   acceleration, one transaction for every input transaction
//   i_cfg_we/i_cfg_data write inv_dt (reset 100); write only while idle
// timing:
//   one item at a time; products go through one shared 2-bit-per-cycle
//   multiplier (11 products), atan2 through one shared cordic (three uses,
//   cut short when y is zero), square roots through one bit-serial root
//   (two uses); the input is ready again once the result is loaded into
//   the output register
// reset:
//   synchronous, active low; clears inv_dt to 100 and previous yaw and
//   rate to zero
// stall:
//   the result holds in the output register until the receiver takes it;
//   the next item runs to its result and waits until the register is free
`timescale 1ns / 1ps
module quaternion_to_euler_yaw_rate_unit
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [13:0] i_cfg_data,
    qte_in_if.sink      in_if,
    qte_out_if.source   out_if
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ROLL, S_YAW, S_SQA, S_SQB, S_PITCH,
        S_RATE, S_ACCEL, S_OUT
    } t_state;

    t_state r_state;
    logic [13:0]        r_inv_dt;
    logic signed [15:0] r_last_yaw;
    logic signed [31:0] r_last_rate;
    logic signed [15:0] r_w, r_x, r_y, r_z;
    logic [3:0]         r_k;
    logic signed [31:0] r_pr [9];
    logic signed [14:0] r_roll, r_yaw;
    logic signed [13:0] r_pitch;
    logic signed [31:0] r_rate;
    logic [24:0]        r_sa, r_sb;
    logic               r_out_valid;

    logic        mul_start, mul_done;
    logic signed [33:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [49:0] mul_p;
    logic        cor_start, cor_done;
    logic signed [39:0] cor_y, cor_x;
    logic signed [23:0] cor_z;
    logic        sq_start, sq_done;
    logic [49:0] sq_n;
    logic [24:0] sq_r;
    logic        r_go;
    logic        out_load;

    logic signed [15:0] op_a, op_b;
    logic signed [39:0] roll_y, roll_x, yaw_y, yaw_x, s_val, ra, rb;
    logic signed [31:0] n_roll_yaw;

    // operand pairs: wx yz xx yy wz xy zz wy xz
    always_comb begin
        case (r_k)
            4'd0: begin op_a = r_w; op_b = r_x; end
            4'd1: begin op_a = r_y; op_b = r_z; end
            4'd2: begin op_a = r_x; op_b = r_x; end
            4'd3: begin op_a = r_y; op_b = r_y; end
            4'd4: begin op_a = r_w; op_b = r_z; end
            4'd5: begin op_a = r_x; op_b = r_y; end
            4'd6: begin op_a = r_z; op_b = r_z; end
            4'd7: begin op_a = r_w; op_b = r_y; end
            default: begin op_a = r_x; op_b = r_z; end
        endcase
    end

    assign roll_y = 40'(2 * (40'(r_pr[0]) + 40'(r_pr[1])));
    assign roll_x = 40'sd268435456 - 40'(2 * (40'(r_pr[2]) + 40'(r_pr[3])));
    assign yaw_y  = 40'(2 * (40'(r_pr[4]) + 40'(r_pr[5])));
    assign yaw_x  = 40'sd268435456 - 40'(2 * (40'(r_pr[3]) + 40'(r_pr[6])));
    assign s_val  = 40'(r_pr[7]) - 40'(r_pr[8]);
    assign ra     = 40'sd268435456 + 2 * s_val;
    assign rb     = 40'sd268435456 - 2 * s_val;

    function automatic logic signed [31:0] to_q12(input logic signed [31:0] v,
                                                  input int lim);
        logic signed [31:0] t;
        t = (v + 32'sd128) >>> 8;
        if (t > lim) t = 32'(lim);
        if (t < -lim) t = -32'(lim);
        return t;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) return 32'h7fffffff;
        if (v < -50'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    always_comb begin
        mul_start = 1'b0;
        mul_a = 34'(op_a);
        mul_b = op_b;
        cor_start = 1'b0;
        cor_y = roll_y;
        cor_x = roll_x;
        sq_start = 1'b0;
        sq_n = '0;
        case (r_state)
            S_MUL: mul_start = r_go;
            S_ROLL: cor_start = r_go;
            S_YAW: begin
                cor_start = r_go;
                cor_y = yaw_y;
                cor_x = yaw_x;
            end
            S_SQA: begin
                sq_start = r_go;
                sq_n = ra[39] ? '0 : {ra[33:0], 16'd0};
            end
            S_SQB: begin
                sq_start = r_go;
                sq_n = rb[39] ? '0 : {rb[33:0], 16'd0};
            end
            S_PITCH: begin
                cor_start = r_go;
                cor_y = 40'(r_sa);
                cor_x = 40'(r_sb);
            end
            S_RATE: begin
                mul_start = r_go;
                mul_a = 34'(32'(r_yaw) - 32'(r_last_yaw));
                mul_b = 16'(r_inv_dt);
            end
            S_ACCEL: begin
                mul_start = r_go;
                mul_a = 34'(r_rate) - 34'(r_last_rate);
                mul_b = 16'(r_inv_dt);
            end
            default: ;
        endcase
    end

    assign n_roll_yaw = to_q12(32'(cor_z), AngMax);
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || out_if.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inv_dt    <= 14'd100;
            r_last_yaw  <= '0;
            r_last_rate <= '0;
            r_out_valid <= 1'b0;
            r_go        <= 1'b0;
            r_k         <= '0;
        end else begin
            if (i_cfg_we) r_inv_dt <= i_cfg_data;
            r_go <= 1'b0;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_if.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_if.valid) begin
                        r_w <= in_if.quat_w;
                        r_x <= in_if.quat_x;
                        r_y <= in_if.quat_y;
                        r_z <= in_if.quat_z;
                        r_k <= '0;
                        r_go <= 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        r_pr[r_k] <= mul_p[31:0];
                        r_go <= 1'b1;
                        if (r_k == 4'd8) begin
                            r_state <= S_ROLL;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_ROLL: if (cor_done) begin
                    r_roll <= n_roll_yaw[14:0];
                    r_go <= 1'b1;
                    r_state <= S_YAW;
                end
                S_YAW: if (cor_done) begin
                    r_yaw <= n_roll_yaw[14:0];
                    r_go <= 1'b1;
                    r_state <= S_SQA;
                end
                S_SQA: if (sq_done) begin
                    r_sa <= sq_r;
                    r_go <= 1'b1;
                    r_state <= S_SQB;
                end
                S_SQB: if (sq_done) begin
                    r_sb <= sq_r;
                    r_go <= 1'b1;
                    r_state <= S_PITCH;
                end
                S_PITCH: if (cor_done) begin
                    r_pitch <= 14'(to_q12(32'(2 * cor_z) - 32'(HalfPiQ20), PitchMax));
                    r_go <= 1'b1;
                    r_state <= S_RATE;
                end
                S_RATE: if (mul_done) begin
                    r_rate <= sat32(mul_p);
                    r_go <= 1'b1;
                    r_state <= S_ACCEL;
                end
                S_ACCEL: if (mul_done) begin
                    r_state <= S_OUT;
                end
                S_OUT: if (out_load) begin
                    out_if.yaw_accel <= sat32(mul_p);
                    out_if.roll_angle <= r_roll;
                    out_if.pitch_angle <= r_pitch;
                    out_if.yaw_angle <= r_yaw;
                    out_if.yaw_rate <= r_rate;
                    r_last_yaw <= 16'(r_yaw);
                    r_last_rate <= r_rate;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign in_if.ready  = i_rst_n && (r_state == S_IDLE);
    assign out_if.valid = r_out_valid;

    qte_mul #(.AW(34), .BW(16)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_p(mul_p)
    );
    qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start),
        .i_y(cor_y), .i_x(cor_x), .o_done(cor_done), .o_z(cor_z)
    );
    qte_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start),
        .i_n(sq_n), .o_done(sq_done), .o_r(sq_r)
    );

    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_if.valid && in_if.ready |=> !in_if.ready) else $error("input accepted while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.yaw_rate))
        else $error("result dropped under stall");
    a_state_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid |-> r_last_rate == out_if.yaw_rate) else $error("rate state mismatch");
endmodule

### sim/tb_top.sv
// testbench for the quaternion to euler yaw rate unit: predicted results checked per transaction
`timescale 1ns / 1ps
module tb_top
    import qte_pkg::*;
();

    localparam int CordicSteps = 16;
    localparam longint OneQ28 = 64'sd1 << 28;
    localparam int CycleLimit = 1500000;

    typedef struct packed {
        logic signed [14:0] roll;
        logic signed [13:0] pitch;
        logic signed [14:0] yaw;
        logic signed [31:0] rate;
        logic signed [31:0] accel;
    } t_euler;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [13:0] i_cfg_data = '0;

    qte_in_if  in_if ();
    qte_out_if out_if ();

    quaternion_to_euler_yaw_rate_unit #(.CORDIC_STEPS(CordicSteps)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .in_if      (in_if.sink),
        .out_if     (out_if.source)
    );

    always #6 i_clk = ~i_clk;

    t_euler      expected_euler[$];
    int          error_count = 0;
    int          cycle_count = 0;
    logic [13:0] model_inv_dt;
    longint      model_last_yaw;
    longint      model_last_rate;
    int          stall_mode = 0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_atan2(longint yv, longint xv);
        longint acc;
        longint xs;
        longint ys;
        acc = 0;
        if (yv == 0) return xv >= 0 ? 0 : longint'(PiQ20);
        if (xv < 0) begin
            acc = yv >= 0 ? longint'(PiQ20) : -longint'(PiQ20);
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < CordicSteps && i < TableLen; i++) begin
            xs = asr(xv, i);
            ys = asr(yv, i);
            if (yv >= 0) begin
                xv = xv + ys;
                yv = yv - xs;
                acc = acc + longint'(atan_entry(i[4:0]));
            end else begin
                xv = xv - ys;
                yv = yv + xs;
                acc = acc - longint'(atan_entry(i[4:0]));
            end
        end
        return acc;
    endfunction

    function automatic longint angle_q12(longint q20, longint lim);
        return clip(asr(q20 + 128, 8), -lim, lim);
    endfunction

    function automatic t_euler predict_euler(t_quat qw, t_quat qx, t_quat qy, t_quat qz);
        longint w;
        longint x;
        longint y;
        longint z;
        longint s;
        longint ra;
        longint rb;
        longint roll;
        longint pitch;
        longint yaw;
        longint rate;
        longint accel;
        t_euler r;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        roll = angle_q12(vector_atan2(2 * (w * x + y * z), OneQ28 - 2 * (x * x + y * y)), AngMax);
        yaw = angle_q12(vector_atan2(2 * (w * z + x * y), OneQ28 - 2 * (y * y + z * z)), AngMax);
        s = w * y - x * z;
        ra = OneQ28 + 2 * s;
        rb = OneQ28 - 2 * s;
        if (ra < 0) ra = 0;
        if (rb < 0) rb = 0;
        pitch = angle_q12(-longint'(HalfPiQ20)
                          + 2 * vector_atan2(int_sqrt(ra << 16), int_sqrt(rb << 16)), PitchMax);
        rate = clip((yaw - model_last_yaw) * longint'(model_inv_dt), -(64'sd1 << 31),
                    (64'sd1 << 31) - 1);
        accel = clip((rate - model_last_rate) * longint'(model_inv_dt), -(64'sd1 << 31),
                     (64'sd1 << 31) - 1);
        model_last_yaw = yaw;
        model_last_rate = rate;
        r.roll = roll[14:0];
        r.pitch = pitch[13:0];
        r.yaw = yaw[14:0];
        r.rate = rate[31:0];
        r.accel = accel[31:0];
        return r;
    endfunction

    task automatic send_quat(t_quat qw, t_quat qx, t_quat qy, t_quat qz);
        t_euler pred;
        in_if.valid  <= 1'b1;
        in_if.quat_w <= qw;
        in_if.quat_x <= qx;
        in_if.quat_y <= qy;
        in_if.quat_z <= qz;
        do @(posedge i_clk); while (!in_if.ready);
        pred = predict_euler(qw, qx, qy, qz);
        expected_euler = {expected_euler, pred};
    endtask

    task automatic send_gap(int gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_wait();
        in_if.valid <= 1'b0;
        while (expected_euler.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_inv_dt(logic [13:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_inv_dt = v;
    endtask

    task automatic send_random(int count, bit full_range);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                send_gap($urandom_range(0, 3) == 0 ? $urandom_range(1, 300) : 0);
                burst = $urandom_range(1, 20);
            end
            burst--;
            if (full_range || $urandom_range(0, 3) == 0)
                send_quat(t_quat'($urandom), t_quat'($urandom), t_quat'($urandom),
                          t_quat'($urandom));
            else
                send_quat(t_quat'($urandom_range(0, 32768) - 16384),
                          t_quat'($urandom_range(0, 16384) - 8192),
                          t_quat'($urandom_range(0, 16384) - 8192),
                          t_quat'($urandom_range(0, 32768) - 16384));
        end
        in_if.valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
        send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_quat(16'sd32767, 16'sd0, 16'sd32767, 16'sd0);
        send_quat(16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
        send_quat(16'sd11585, 16'sd0, 16'sd0, -16'sd11585);
        send_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
        send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
        send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        drain_wait();
    endtask

    task automatic test_inv_dt_extremes();
        write_inv_dt(14'd0);
        send_random(40, 1'b0);
        drain_wait();
        write_inv_dt(14'd16383);
        send_random(60, 1'b1);
        drain_wait();
        write_inv_dt(14'd1);
        send_random(40, 1'b0);
        drain_wait();
        write_inv_dt(14'd10000);
        send_random(40, 1'b0);
        drain_wait();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            write_inv_dt(14'($urandom_range(1, 16383)));
            stall_mode = phase % 3;
            send_random(180, phase == 5);
            drain_wait();
        end
        stall_mode = 0;
    endtask

    always @(posedge i_clk) begin
        case (stall_mode)
            0: out_if.ready <= ($urandom_range(0, 3) != 0);
            1: out_if.ready <= 1'b1;
            default: out_if.ready <= (cycle_count % 50) < 5;
        endcase
    end

    always @(posedge i_clk) begin
        t_euler want;
        t_euler got;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.roll_angle, out_if.pitch_angle, out_if.yaw_angle,
                   out_if.yaw_rate, out_if.yaw_accel};
            if (expected_euler.size() == 0) begin
                $display("%0t unexpected transaction got %p", $time, got);
                error_count++;
            end else begin
                want = expected_euler.pop_front();
                if (got.roll !== want.roll) begin
                    $display("%0t roll exp %0d act %0d", $time, want.roll, got.roll);
                    error_count++;
                end
                if (got.pitch !== want.pitch) begin
                    $display("%0t pitch exp %0d act %0d", $time, want.pitch, got.pitch);
                    error_count++;
                end
                if (got.yaw !== want.yaw) begin
                    $display("%0t yaw exp %0d act %0d", $time, want.yaw, got.yaw);
                    error_count++;
                end
                if (got.rate !== want.rate) begin
                    $display("%0t rate exp %0d act %0d", $time, want.rate, got.rate);
                    error_count++;
                end
                if (got.accel !== want.accel) begin
                    $display("%0t accel exp %0d act %0d", $time, want.accel, got.accel);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CycleLimit) begin
            $display("quaternion_to_euler_yaw_rate_unit verification failed");
            $finish;
        end
    end

    initial begin
        in_if.valid  = 1'b0;
        in_if.quat_w = '0;
        in_if.quat_x = '0;
        in_if.quat_y = '0;
        in_if.quat_z = '0;
        model_inv_dt = 14'd100;
        model_last_yaw = 0;
        model_last_rate = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_inv_dt_extremes();
        test_random_traffic();
        if (error_count == 0 && expected_euler.size() == 0)
            $display("quaternion_to_euler_yaw_rate_unit verification clean");
        else
            $display("quaternion_to_euler_yaw_rate_unit verification failed");
        $finish;
    end
endmodule

### quaternion_to_euler_yaw_rate_unit.f
src/qte_pkg.sv
src/qte_if.sv
src/qte_mul.sv
src/qte_isqrt.sv
src/qte_cordic.sv
src/quaternion_to_euler_yaw_rate_unit.sv
sim/tb_top.sv
